// ===== src/tsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp frame parser package
// Frame layout constants, header reset values and register indexes.
// ----------------------------------------------------------------------------
package tsfp_pkg;

  // Frame position field and last (checksum) position
  localparam int unsigned POS_W = 4;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_HDR_FIRST  = 4'd0;
  localparam pos_t POS_HDR_SECOND = 4'd1;
  localparam pos_t POS_PAYLOAD    = 4'd2;
  localparam pos_t POS_COUNT_MSB  = 4'd3;
  localparam pos_t POS_CHECKSUM   = 4'd11;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned TOTAL_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_HEADER_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_HEADER_SECOND = 2'd1;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;

  // Result frame status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

endpackage

// ===== src/timestamp_frame_parser.sv =====
// A frame's result is registered and valid in the cycle after its checksum beat is taken.
// Throughput: one byte per cycle; the frame state updates in a single pass.
// A result waiting at the output stalls input only when the next byte is itself a
// checksum byte, since the single result register is the only buffer.
// Reset (rst_n, synchronous, active low) restores headers 0x55/0xAA, returns to
// header hunting and clears the good-frame count.
// ----------------------------------------------------------------------------
// Timestamp frame parser
// Hunts for a two-byte header, collects a 64-bit big-endian count, checks the
// XOR checksum and emits count, status and a running good-frame total.
// ----------------------------------------------------------------------------
module timestamp_frame_parser
  import tsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,

  // frame result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_frame_status,
  output logic [COUNT_W-1:0]    out_tick_count,
  output logic [TOTAL_W-1:0]    out_good_frames,

  // configuration writes
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [BYTE_W-1:0] header_first_r;
  logic [BYTE_W-1:0] header_second_r;

  // Frame state
  logic               in_payload_r,  in_payload_nxt;
  pos_t               pos_r,         pos_nxt;
  logic [BYTE_W-1:0]  xor_r,         xor_nxt;
  logic [COUNT_W-1:0] count_r,       count_nxt;
  logic [TOTAL_W-1:0] good_total_r,  good_total_nxt;

  // Result register
  logic               out_valid_r,   out_valid_nxt;
  logic               status_r,      status_nxt;
  logic [COUNT_W-1:0] tick_count_r,  tick_count_nxt;
  logic [TOTAL_W-1:0] good_frames_r, good_frames_nxt;

  logic in_beat;
  logic at_checksum;
  logic emit;
  logic checksum_ok;

  // Next byte closes a frame; only then does the result register need room
  assign at_checksum = in_payload_r && (pos_r >= POS_CHECKSUM);
  assign in_ready    = !(at_checksum && out_valid_r && !out_ready);
  assign in_beat     = in_valid && in_ready;
  assign emit        = in_beat && at_checksum;
  assign checksum_ok = (in_rx_byte == xor_r);

  // Configuration writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first_r  <= cfg_wdata;
        CFG_HEADER_SECOND: header_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state update for one accepted beat
  always_comb begin
    in_payload_nxt = in_payload_r;
    pos_nxt        = pos_r;
    xor_nxt        = xor_r;
    count_nxt      = count_r;
    good_total_nxt = good_total_r;
    if (in_beat) begin
      if (!in_payload_r) begin
        // header hunt
        priority if (in_rx_byte == header_first_r && pos_r == POS_HDR_FIRST) begin
          pos_nxt = POS_HDR_SECOND;
        end else if (in_rx_byte == header_second_r && pos_r == POS_HDR_SECOND) begin
          pos_nxt        = POS_PAYLOAD;
          in_payload_nxt = 1'b1;
          xor_nxt        = '0;
          count_nxt      = '0;
        end else begin
          pos_nxt = POS_HDR_FIRST;
        end
      end else if (!at_checksum) begin
        // payload and count bytes
        xor_nxt = xor_r ^ in_rx_byte;
        if (pos_r >= POS_COUNT_MSB) begin
          count_nxt = {count_r[COUNT_W-BYTE_W-1:0], in_rx_byte};
        end
        pos_nxt = pos_r + pos_t'(1);
      end else begin
        // checksum byte closes the frame
        if (checksum_ok) begin
          good_total_nxt = good_total_r + TOTAL_W'(1);
        end
        in_payload_nxt = 1'b0;
        pos_nxt        = POS_HDR_FIRST;
        xor_nxt        = '0;
      end
    end
  end

  // Result register load and drain
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ready;
    status_nxt      = status_r;
    tick_count_nxt  = tick_count_r;
    good_frames_nxt = good_frames_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      status_nxt      = checksum_ok ? STATUS_GOOD : STATUS_BAD;
      tick_count_nxt  = count_r;
      good_frames_nxt = good_total_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      pos_r        <= POS_HDR_FIRST;
      xor_r        <= '0;
      count_r      <= '0;
      good_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      pos_r        <= pos_nxt;
      xor_r        <= xor_nxt;
      count_r      <= count_nxt;
      good_total_r <= good_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r      <= status_nxt;
    tick_count_r  <= tick_count_nxt;
    good_frames_r <= good_frames_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;
  assign out_tick_count   = tick_count_r;
  assign out_good_frames  = good_frames_r;

  // Hunting only ever sits at one of the two header positions
  a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_payload_r |-> (pos_r == POS_HDR_FIRST || pos_r == POS_HDR_SECOND))
    else $error("header hunt at payload position");

  // Payload positions never fall back into the header range
  a_payload_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (pos_r >= POS_PAYLOAD && pos_r <= POS_CHECKSUM))
    else $error("payload position out of range");

  // A checksum beat yields a result and returns to header hunting
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && !in_payload_r && pos_r == POS_HDR_FIRST))
    else $error("checksum beat lost");

  // Input stalls only when a result is blocked and the next byte closes a frame
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && at_checksum))
    else $error("unexpected input stall");

  // Good-frame total moves by one, only on a good checksum beat
  a_good_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (good_total_nxt != good_total_r) |-> (emit && checksum_ok &&
      good_total_nxt == good_total_r + TOTAL_W'(1)))
    else $error("good-frame total changed outside a good frame");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timestamp frame parser testbench
// Streams byte beats into the parser: a few directed frames and sync-loss
// cases, then phases of mostly well-formed random frames mixed with noise,
// repeated and truncated headers, under several header settings. A tracking
// model of the frame hunter predicts every result, which the monitor checks
// field by field. Both sides idle at random in most phases; one phase holds the result
// side off for a long stretch while bytes keep coming.
// ----------------------------------------------------------------------------
module tb_top;
  import tsfp_pkg::*;

  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 6;

  // Register indexes the block does not map
  localparam cfg_idx_t CFG_IDX_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_IDX_SPARE_HI = 2'd3;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
  } frame_result_t;

  // DUT signals; inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_frame_status;
  logic [COUNT_W-1:0]    out_tick_count;
  logic [TOTAL_W-1:0]    out_good_frames;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_HEADER_FIRST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Stimulus and checking state
  logic [BYTE_W-1:0] pending_bytes[$];
  frame_result_t     expected_results[$];
  int unsigned       errors = 0;
  int unsigned       in_gap = 0;
  int unsigned       out_hold = 0;
  int unsigned       hold_requests = 0;
  int unsigned       holds_served = 0;
  bit                in_gaps_on = 1'b1;
  bit                out_stalls_on = 1'b1;

  // Tracking model of the frame hunter
  logic [BYTE_W-1:0]  fp_hdr_first = HEADER_FIRST_RST;
  logic [BYTE_W-1:0]  fp_hdr_second = HEADER_SECOND_RST;
  logic               fp_in_frame = 1'b0;
  pos_t               fp_pos = POS_HDR_FIRST;
  logic [BYTE_W-1:0]  fp_xor = '0;
  logic [COUNT_W-1:0] fp_count = '0;
  logic [TOTAL_W-1:0] fp_good = '0;

  timestamp_frame_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_tick_count   (out_tick_count),
    .out_good_frames  (out_good_frames),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the frame hunter by one taken byte; queue a result on the checksum
  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    if (!fp_in_frame) begin
      if (b == fp_hdr_first && fp_pos == POS_HDR_FIRST) begin
        fp_pos = POS_HDR_SECOND;
      end else if (b == fp_hdr_second && fp_pos == POS_HDR_SECOND) begin
        fp_pos      = POS_PAYLOAD;
        fp_in_frame = 1'b1;
        fp_xor      = '0;
        fp_count    = '0;
      end else begin
        fp_pos = POS_HDR_FIRST;
      end
    end else if (fp_pos < POS_CHECKSUM) begin
      fp_xor = fp_xor ^ b;
      if (fp_pos >= POS_COUNT_MSB)
        fp_count = {fp_count[COUNT_W-BYTE_W-1:0], b};
      fp_pos = fp_pos + 1'b1;
    end else begin
      r.status = (b == fp_xor) ? STATUS_GOOD : STATUS_BAD;
      if (r.status == STATUS_GOOD)
        fp_good = fp_good + 1'b1;
      r.count = fp_count;
      r.total = fp_good;
      expected_results.push_back(r);
      fp_in_frame = 1'b0;
      fp_pos      = POS_HDR_FIRST;
      fp_xor      = '0;
    end
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Queue one full frame; a bad frame gets a corrupted checksum
  task automatic push_frame(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                            input logic [BYTE_W-1:0] pay, input logic [COUNT_W-1:0] cnt,
                            input bit bad);
    logic [BYTE_W-1:0] ck;
    ck = pay;
    pending_bytes.push_back(h1);
    pending_bytes.push_back(h2);
    pending_bytes.push_back(pay);
    for (int i = COUNT_W / BYTE_W - 1; i >= 0; i--) begin
      pending_bytes.push_back(cnt[i*BYTE_W +: BYTE_W]);
      ck = ck ^ cnt[i*BYTE_W +: BYTE_W];
    end
    if (bad)
      ck = ck ^ BYTE_W'($urandom_range(1, 255));
    pending_bytes.push_back(ck);
  endtask

  // Mostly well-formed frames, with noise and broken syncs in between
  task automatic run_random(input int unsigned n_bytes);
    int unsigned r;
    int unsigned k;
    for (int unsigned sent = 0; sent < n_bytes; sent = sent + 1) begin
      r = $urandom_range(0, 99);
      k = pending_bytes.size();
      if (r < 70) begin
        push_frame(fp_hdr_first, fp_hdr_second, BYTE_W'($urandom), pick_count(),
                   $urandom_range(0, 4) == 0);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 6)) pending_bytes.push_back(BYTE_W'($urandom));
      end else if (r < 88) begin
        // repeated first header breaks the sync of the frame behind it
        pending_bytes.push_back(fp_hdr_first);
        push_frame(fp_hdr_first, fp_hdr_second, BYTE_W'($urandom), pick_count(), 1'b0);
      end else if (r < 96) begin
        // truncated frame: the next bytes land in its payload
        pending_bytes.push_back(fp_hdr_first);
        pending_bytes.push_back(fp_hdr_second);
        repeat ($urandom_range(0, 9)) pending_bytes.push_back(BYTE_W'($urandom));
      end else begin
        pending_bytes.push_back(fp_hdr_first);
        pending_bytes.push_back(BYTE_W'($urandom));
      end
      sent = sent + (pending_bytes.size() - k) - 1;
    end
  endtask

  // Wait until every byte is taken and every result has come back
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEADER_FIRST)
      fp_hdr_first = val;
    else if (idx == CFG_HEADER_SECOND)
      fp_hdr_second = val;
  endtask

  // Byte driver: offers the next queued byte, holds it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        parse_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
          in_gap     <= in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken beat against the oldest expectation
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    int unsigned   g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d count %h total %0d",
                 out_frame_status, out_tick_count, out_good_frames);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_frame_status !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, out_frame_status);
            errors = errors + 1;
          end
          if (out_tick_count !== want.count) begin
            $error("tick_count: expected %h, got %h", want.count, out_tick_count);
            errors = errors + 1;
          end
          if (out_good_frames !== want.total) begin
            $error("good_frames: expected %0d, got %0d", want.total, out_good_frames);
            errors = errors + 1;
          end
        end
      end
      // ready for the next cycle: long hold on request, else random stalls
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold  <= out_hold - 1;
      end else if (hold_requests != holds_served) begin
        out_ready    <= 1'b0;
        out_hold     <= LONG_HOLD_CYCLES;
        holds_served <= holds_served + 1;
      end else if (out_stalls_on) begin
        g = pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          out_hold  <= g - 1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Phases
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: repeated first header loses sync, then all-zero good frame
    // and all-ones frame with a bad checksum
    pending_bytes.push_back(HEADER_FIRST_RST);
    pending_bytes.push_back(HEADER_FIRST_RST);
    pending_bytes.push_back(HEADER_SECOND_RST);
    push_frame(HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, '0, 1'b0);
    push_frame(HEADER_FIRST_RST, HEADER_SECOND_RST, 8'hFF, '1, 1'b1);
    wait_idle();

    // Reset headers, idling on both sides
    run_random(200);
    wait_idle();

    // Extreme headers and unmapped indexes, no idling at all
    write_reg(CFG_HEADER_FIRST, 8'h00);
    write_reg(CFG_HEADER_SECOND, 8'hFF);
    write_reg(CFG_IDX_SPARE_LO, 8'h12);
    write_reg(CFG_IDX_SPARE_HI, 8'hED);
    in_gaps_on    <= 1'b0;
    out_stalls_on <= 1'b0;
    run_random(120);
    wait_idle();

    // Swapped extremes; result side held off while frames stream back to back
    write_reg(CFG_HEADER_FIRST, 8'hFF);
    write_reg(CFG_HEADER_SECOND, 8'h00);
    hold_requests <= hold_requests + 1;
    repeat (4)
      push_frame(fp_hdr_first, fp_hdr_second, BYTE_W'($urandom), pick_count(), 1'b0);
    run_random(80);
    wait_idle();

    // Both headers equal: the repeated byte counts as the second header
    write_reg(CFG_HEADER_FIRST, 8'h3C);
    write_reg(CFG_HEADER_SECOND, 8'h3C);
    in_gaps_on    <= 1'b1;
    out_stalls_on <= 1'b1;
    run_random(120);
    wait_idle();

    // Random headers
    write_reg(CFG_HEADER_FIRST, CFG_DATA_W'($urandom));
    write_reg(CFG_HEADER_SECOND, CFG_DATA_W'($urandom));
    run_random(200);
    wait_idle();

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
